// ===== hdl/jsu_pkg.sv =====
// types, codes and helpers shared by the json string unescape decoder
// no dependencies

package jsu_pkg;

    // decoder mode, one-hot
    typedef enum logic [6:0] {
        MODE_AWAIT = 7'b0000001,
        MODE_BODY  = 7'b0000010,
        MODE_ESC   = 7'b0000100,
        MODE_HEX0  = 7'b0001000,
        MODE_HEX1  = 7'b0010000,
        MODE_HEX2  = 7'b0100000,
        MODE_HEX3  = 7'b1000000
    } mode_t;

    typedef enum logic [2:0] {
        ST_ONGOING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_BAD_ESC  = 3'd2,
        ST_BAD_HEX  = 3'd3,
        ST_UNCLOSED = 3'd4
    } status_t;

    // results caused by one input byte, data[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      last_idx;
        logic            byte_valid;
        status_t         status;
    } pkt_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// per-byte decode: next mode, hex accumulator and the result packet
// depends on jsu_pkg

module jsu_decode (
    input  jsu_pkg::mode_t mode,
    input  logic [11:0]    hex_accum,
    input  logic [7:0]     in_byte,
    output jsu_pkg::mode_t mode_next,
    output logic [11:0]    hex_next,
    output jsu_pkg::pkt_t  pkt
);
    import jsu_pkg::*;

    logic [4:0]  hd;
    logic [15:0] cp;

    assign hd = hex_digit(in_byte);
    assign cp = {hex_accum, hd[3:0]};

    always_comb begin
        mode_next      = mode;
        hex_next       = hex_accum;
        pkt.data       = '0;
        pkt.last_idx   = 2'd0;
        pkt.byte_valid = 1'b0;
        pkt.status     = ST_ONGOING;

        unique case (mode)
            MODE_BODY: begin
                if (in_byte == CH_QUOTE) begin
                    mode_next  = MODE_AWAIT;
                    hex_next   = '0;
                    pkt.status = ST_DONE;
                end else if (in_byte == CH_NUL) begin
                    mode_next  = MODE_AWAIT;
                    hex_next   = '0;
                    pkt.status = ST_UNCLOSED;
                end else if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    pkt.data[0]    = in_byte;
                    pkt.byte_valid = 1'b1;
                end
            end
            MODE_ESC: begin
                mode_next      = MODE_BODY;
                pkt.byte_valid = 1'b1;
                unique case (in_byte)
                    CH_QUOTE:  pkt.data[0] = CH_QUOTE;
                    CH_BSLASH: pkt.data[0] = CH_BSLASH;
                    CH_SLASH:  pkt.data[0] = CH_SLASH;
                    CH_B:      pkt.data[0] = CTL_BS;
                    CH_F:      pkt.data[0] = CTL_FF;
                    CH_N:      pkt.data[0] = CTL_LF;
                    CH_R:      pkt.data[0] = CTL_CR;
                    CH_T:      pkt.data[0] = CTL_HT;
                    CH_U: begin
                        mode_next      = MODE_HEX0;
                        hex_next       = '0;
                        pkt.byte_valid = 1'b0;
                    end
                    default: begin
                        mode_next      = MODE_AWAIT;
                        hex_next       = '0;
                        pkt.byte_valid = 1'b0;
                        pkt.status     = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (!hd[4]) begin
                    mode_next  = MODE_AWAIT;
                    hex_next   = '0;
                    pkt.status = ST_BAD_HEX;
                end else if (mode != MODE_HEX3) begin
                    hex_next = {hex_accum[7:0], hd[3:0]};
                    unique case (mode)
                        MODE_HEX0: mode_next = MODE_HEX1;
                        MODE_HEX1: mode_next = MODE_HEX2;
                        default:   mode_next = MODE_HEX3;
                    endcase
                end else begin
                    // last hex digit: emit the code point as utf-8
                    mode_next      = MODE_BODY;
                    hex_next       = '0;
                    pkt.byte_valid = 1'b1;
                    if (cp[15:7] == '0) begin
                        pkt.data[0] = cp[7:0];
                    end else if (cp[15:11] == '0) begin
                        pkt.data[0]  = {3'b110, cp[10:6]};
                        pkt.data[1]  = {2'b10, cp[5:0]};
                        pkt.last_idx = 2'd1;
                    end else begin
                        pkt.data[0]  = {4'b1110, cp[15:12]};
                        pkt.data[1]  = {2'b10, cp[11:6]};
                        pkt.data[2]  = {2'b10, cp[5:0]};
                        pkt.last_idx = 2'd2;
                    end
                end
            end
            default: begin
                // awaiting the opening quote: any byte is taken as the quote
                mode_next = MODE_BODY;
                hex_next  = '0;
            end
        endcase
    end

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// json string unescape decoder with utf-8 output for \u escapes
// depends on jsu_pkg and jsu_decode
//
// Usage:
//   s_valid/s_ready/s_in_byte carry the string one byte per item, starting
//   with its opening quote. m_valid/m_ready carry result items: m_out_byte,
//   m_byte_valid, m_status (0 ongoing, 1 complete, 2 bad escape, 3 bad hex
//   digit, 4 unclosed string) and m_last on the final result of an input byte.
//   The first result of an input byte passes through the input register,
//   then the result register, before it is offered on the output.
//   Throughput: one input byte per cycle while each byte gives one result
//   and m_ready stays high; the fourth hex digit of a \u escape gives one,
//   two or three results and holds the result register until all are taken,
//   as the single output port carries one result at a time.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   decoder to waiting for an opening quote.
//   When m_ready is low the result waits in the result register, one more
//   byte is taken into the input register, then s_ready drops.

module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic [2:0] m_status,
    output logic       m_last
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [11:0] hex_reg, hex_next;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        res_valid_reg, res_valid_next;
    pkt_t        pkt_reg, pkt_dec;
    logic [1:0]  idx_reg, idx_next;
    logic        res_done;
    logic        move;

    jsu_decode u_decode (
        .mode      (mode_reg),
        .hex_accum (hex_reg),
        .in_byte   (in_byte_reg),
        .mode_next (mode_next),
        .hex_next  (hex_next),
        .pkt       (pkt_dec)
    );

    assign res_done = res_valid_reg && m_ready && (idx_reg == pkt_reg.last_idx);
    assign move     = in_valid_reg && (!res_valid_reg || res_done);
    assign s_ready  = !in_valid_reg || move;

    always_comb begin
        in_valid_next  = in_valid_reg;
        res_valid_next = res_valid_reg;
        idx_next       = idx_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (move) begin
            in_valid_next = 1'b0;
        end
        if (move) begin
            res_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (res_done) begin
            res_valid_next = 1'b0;
        end else if (res_valid_reg && m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_AWAIT;
            hex_reg       <= '0;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
            if (move) begin
                mode_reg <= mode_next;
                hex_reg  <= hex_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (move) begin
            pkt_reg <= pkt_dec;
        end
    end

    assign m_valid      = res_valid_reg;
    assign m_out_byte   = pkt_reg.data[idx_reg];
    assign m_byte_valid = pkt_reg.byte_valid;
    assign m_status     = pkt_reg.status;
    assign m_last       = (idx_reg == pkt_reg.last_idx);

    // a result without data is always the only one of its byte
    a_nodata_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_last)
        else $error("data-less result is not last");

    // end of string never carries data
    a_end_nodata: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_ONGOING) |-> (!m_byte_valid && m_last))
        else $error("string end result carries data");

    // the output index never runs past the last result of a packet
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg <= pkt_reg.last_idx))
        else $error("result index beyond packet");

    // a finished string leaves the decoder waiting with a clear accumulator
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && pkt_dec.status != ST_ONGOING) |=> (mode_reg == MODE_AWAIT && hex_reg == '0))
        else $error("decoder not reset after string end");

endmodule

// ===== dv/tb_json_string_unescape_utf8.sv =====
// self-checking testbench for json_string_unescape_utf8: directed and random json strings,
// each accepted byte decoded by an in-bench unescape model and compared per result item
// depends on jsu_pkg and the rtl of json_string_unescape_utf8

module tb_json_string_unescape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    typedef enum logic [1:0] {
        DEC_AWAIT,
        DEC_BODY,
        DEC_ESC,
        DEC_HEX
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        status_t    status;
        logic       last;
    } unesc_res_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic [2:0] m_status;
    logic       m_last;

    logic [7:0]  text_q [$];
    unesc_res_t  decoded_q [$];

    // unescape model state
    dec_state_t  dec_state = DEC_AWAIT;
    int unsigned hex_taken = 0;
    logic [11:0] code_acc = '0;

    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    logic        quiet = 1'b0;
    logic        hold_out = 1'b0;
    int unsigned cyc_cnt = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned strings_ok = 0;
    int unsigned strings_bad = 0;
    int unsigned mismatches = 0;

    logic [7:0]  esc_chars [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [15:0] bound_cps [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

    json_string_unescape_utf8 i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_byte_valid(m_byte_valid),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // {is hex digit, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return (($urandom_range(0, 1) == 1) ? 8'h37 : 8'h57) + n;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_result(input logic [7:0] data, input logic valid, input status_t st,
                               input logic lst);
        unesc_res_t res;
        res.data = data;
        res.valid = valid;
        res.status = st;
        res.last = lst;
        decoded_q.push_back(res);
    endtask

    task automatic end_string(input status_t st);
        dec_state = DEC_AWAIT;
        code_acc = '0;
        push_result(8'h00, 1'b0, st, 1'b1);
    endtask

    // expected result items for one accepted input byte
    task automatic unescape_byte(input logic [7:0] c);
        logic [4:0]  nib;
        logic [7:0]  esc;
        logic        known;
        logic [15:0] cp;
        unique case (dec_state)
            DEC_BODY: begin
                if (c == CH_QUOTE) begin
                    end_string(ST_DONE);
                end else if (c == CH_NUL) begin
                    end_string(ST_UNCLOSED);
                end else if (c == CH_BSLASH) begin
                    dec_state = DEC_ESC;
                    push_result(8'h00, 1'b0, ST_ONGOING, 1'b1);
                end else begin
                    push_result(c, 1'b1, ST_ONGOING, 1'b1);
                end
            end
            DEC_ESC: begin
                known = 1'b1;
                esc = c;
                unique case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
                    CH_B: esc = CTL_BS;
                    CH_F: esc = CTL_FF;
                    CH_N: esc = CTL_LF;
                    CH_R: esc = CTL_CR;
                    CH_T: esc = CTL_HT;
                    default: known = 1'b0;
                endcase
                if (c == CH_U) begin
                    dec_state = DEC_HEX;
                    hex_taken = 0;
                    code_acc = '0;
                    push_result(8'h00, 1'b0, ST_ONGOING, 1'b1);
                end else if (known) begin
                    dec_state = DEC_BODY;
                    push_result(esc, 1'b1, ST_ONGOING, 1'b1);
                end else begin
                    end_string(ST_BAD_ESC);
                end
            end
            DEC_HEX: begin
                nib = hex_val(c);
                if (!nib[4]) begin
                    end_string(ST_BAD_HEX);
                end else if (hex_taken < 3) begin
                    code_acc = {code_acc[7:0], nib[3:0]};
                    hex_taken++;
                    push_result(8'h00, 1'b0, ST_ONGOING, 1'b1);
                end else begin
                    cp = {code_acc, nib[3:0]};
                    dec_state = DEC_BODY;
                    code_acc = '0;
                    if (cp <= 16'h007F) begin
                        push_result(cp[7:0], 1'b1, ST_ONGOING, 1'b1);
                    end else if (cp <= 16'h07FF) begin
                        push_result({3'b110, cp[10:6]}, 1'b1, ST_ONGOING, 1'b0);
                        push_result({2'b10, cp[5:0]}, 1'b1, ST_ONGOING, 1'b1);
                    end else begin
                        push_result({4'b1110, cp[15:12]}, 1'b1, ST_ONGOING, 1'b0);
                        push_result({2'b10, cp[11:6]}, 1'b1, ST_ONGOING, 1'b0);
                        push_result({2'b10, cp[5:0]}, 1'b1, ST_ONGOING, 1'b1);
                    end
                end
            end
            default: begin
                // any byte opens the string
                dec_state = DEC_BODY;
                code_acc = '0;
                push_result(8'h00, 1'b0, ST_ONGOING, 1'b1);
            end
        endcase
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic add_code_point(input logic [15:0] cp);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int k = 3; k >= 0; k--) text_q.push_back(hex_char(cp[4*k +: 4]));
    endtask

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt % 64 == 0) quiet <= ($urandom_range(0, 2) == 0);
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'h00;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                unescape_byte(s_in_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || text_q.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    s_valid <= 1'b1;
                    s_in_byte <= text_q.pop_front();
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else if (hold_out) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // long hold-off so the block fills up and stalls its input
    initial begin
        while (bytes_sent < 120) @(posedge aclk);
        hold_out <= 1'b1;
        repeat (150) @(posedge aclk);
        hold_out <= 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        unesc_res_t  want;
        int unsigned errs;
        errs = 0;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (decoded_q.size() == 0) begin
                $error("result item with nothing expected: out_byte %h status %0d",
                       m_out_byte, m_status);
                errs++;
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, m_out_byte);
                    errs++;
                end
                if (m_byte_valid !== want.valid) begin
                    $error("byte_valid: expected %b, got %b", want.valid, m_byte_valid);
                    errs++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errs++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    errs++;
                end
                if (want.status == ST_DONE) strings_ok <= strings_ok + 1;
                else if (want.status != ST_ONGOING) strings_bad <= strings_bad + 1;
            end
            if (errs != 0) mismatches <= mismatches + errs;
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [7:0]  b;
        logic [15:0] cp;
        int          n_elem;
        int          pick;
        int          r;
        bit          broken;

        // directed: nul as opening byte, plain 0xff, code point zero and max, then errors
        text_q.push_back(CH_NUL);
        text_q.push_back(8'hFF);
        add_code_point(16'h0000);
        add_code_point(16'hFFFF);
        put_text("\"");
        put_text("x\\q");
        put_text("\"\\");
        text_q.push_back(CH_NUL);
        put_text("\"");
        text_q.push_back(CH_NUL);
        put_text("\"\\u");
        text_q.push_back(CH_NUL);

        // random strings, mostly well formed
        while (text_q.size() < 420) begin
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(0, 255));
                text_q.push_back(b);
            end else begin
                text_q.push_back(CH_QUOTE);
            end
            n_elem = $urandom_range(0, 10);
            broken = 1'b0;
            for (int k = 0; k < n_elem && !broken; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                    text_q.push_back(b);
                end else if (pick < 70) begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(esc_chars[$urandom_range(0, 7)]);
                end else if (pick < 93) begin
                    r = $urandom_range(0, 3);
                    if (r == 0) cp = 16'($urandom_range(0, 16'h007F));
                    else if (r == 1) cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    else if (r == 2) cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    else cp = bound_cps[$urandom_range(0, 7)];
                    add_code_point(cp);
                end else begin
                    broken = 1'b1;
                    r = $urandom_range(0, 2);
                    if (r == 0) begin
                        // unknown escape letter, nul possible
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B
                               || b == CH_F || b == CH_N || b == CH_R || b == CH_T
                               || b == CH_U);
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(b);
                    end else if (r == 1) begin
                        // \u cut short by a non-hex byte
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(CH_U);
                        repeat ($urandom_range(0, 3)) begin
                            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                        end
                        do b = 8'($urandom_range(0, 255)); while (hex_val(b) != 5'b0);
                        text_q.push_back(b);
                    end else begin
                        text_q.push_back(CH_NUL);
                    end
                end
            end
            if (!broken) text_q.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d input bytes, checked %0d result items", bytes_sent, results_seen);
        $display("%0d strings closed normally, %0d ended in an error", strings_ok, strings_bad);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
